/* hw/rtl/rv32im_integer_alu_assert.svh */
// Assertion macros for the port-level checker of the integer ALU.
// No dependencies.
`ifndef RV32IM_INTEGER_ALU_ASSERT_SVH
`define RV32IM_INTEGER_ALU_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define RIA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define RIA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* hw/rtl/ria_pkg.sv */
// Package for the integer ALU: command codes, result kinds, stage payload type.
// No dependencies.
`default_nettype none
package ria_pkg;
    localparam int unsigned NumCells = 32;

    typedef enum logic [4:0] {
        CMD_ADD = 5'd0, CMD_SUB = 5'd1, CMD_SLL = 5'd2, CMD_SLT = 5'd3,
        CMD_SLTU = 5'd4, CMD_XOR = 5'd5, CMD_SRL = 5'd6, CMD_SRA = 5'd7,
        CMD_OR = 5'd8, CMD_AND = 5'd9, CMD_MUL = 5'd10, CMD_MULH = 5'd11,
        CMD_MULHSU = 5'd12, CMD_MULHU = 5'd13, CMD_DIV = 5'd14,
        CMD_DIVU = 5'd15, CMD_REM = 5'd16, CMD_REMU = 5'd17
    } cmd_t;

    // Sequence of result kinds at the end of the chain.
    typedef enum logic [2:0] {
        K_DIRECT, K_MULLO, K_MULHI, K_QUOT, K_REMD
    } kind_t;

    // Payload carried cell to cell.
    typedef struct packed {
        logic        vld;
        kind_t       kind;
        logic        zero_rd;
        logic        neg_res;   // negate final (hi product / quotient / remainder)
        logic [31:0] direct;    // result of the direct ops and of divide special cases
        logic        use_direct;
        logic [31:0] dvs;       // divisor magnitude, or multiplicand (b)
        logic [31:0] rem;       // partial remainder, or upper product
        logic [31:0] quo;       // dividend/quotient shift, or lower product
    } cell_t;
endpackage
`default_nettype wire

/* hw/rtl/ria_front.sv */
// Front stage of the integer ALU: direct ops, special cases, operand prep.
// Depends on ria_pkg.
`default_nettype none
module ria_front (
    input  wire logic [4:0]      command,
    input  wire logic [31:0]     operand_a,
    input  wire logic [31:0]     operand_b,
    input  wire logic [4:0]      dest_reg,
    input  wire logic            vld,
    output ria_pkg::cell_t       seed
);
    logic [4:0]  sh;
    logic        na, nb, ovf, bz;
    logic [31:0] ma, mb;
    logic [31:0] sra_v;

    assign sh  = operand_b[4:0];
    assign na  = operand_a[31];
    assign nb  = operand_b[31];
    assign ovf = (operand_a == 32'h8000_0000) && (operand_b == 32'hffff_ffff);
    assign bz  = (operand_b == 32'd0);
    assign ma  = na ? (32'd0 - operand_a) : operand_a;
    assign mb  = nb ? (32'd0 - operand_b) : operand_b;
    assign sra_v = 32'($signed(operand_a) >>> sh);

    // Decode and prime the chain.
    always_comb begin
        seed = '0;
        seed.vld = vld;
        seed.zero_rd = (dest_reg == 5'd0);
        seed.kind = ria_pkg::K_DIRECT;
        seed.use_direct = 1'b1;
        unique case (command) inside
            ria_pkg::CMD_ADD:  seed.direct = operand_a + operand_b;
            ria_pkg::CMD_SUB:  seed.direct = operand_a - operand_b;
            ria_pkg::CMD_SLL:  seed.direct = operand_a << sh;
            ria_pkg::CMD_SLT:  seed.direct = {31'd0, $signed(operand_a) < $signed(operand_b)};
            ria_pkg::CMD_SLTU: seed.direct = {31'd0, operand_a < operand_b};
            ria_pkg::CMD_XOR:  seed.direct = operand_a ^ operand_b;
            ria_pkg::CMD_SRL:  seed.direct = operand_a >> sh;
            ria_pkg::CMD_SRA:  seed.direct = sra_v;
            ria_pkg::CMD_OR:   seed.direct = operand_a | operand_b;
            ria_pkg::CMD_AND:  seed.direct = operand_a & operand_b;
            ria_pkg::CMD_MUL, ria_pkg::CMD_MULH, ria_pkg::CMD_MULHSU,
            ria_pkg::CMD_MULHU: begin
                seed.use_direct = 1'b0;
                seed.kind = (command == ria_pkg::CMD_MUL) ? ria_pkg::K_MULLO
                                                          : ria_pkg::K_MULHI;
                // Unsigned product, signed operands taken as magnitudes; sign applied at the end.
                if (command == ria_pkg::CMD_MULH) begin
                    seed.quo = ma; seed.dvs = mb; seed.neg_res = na ^ nb;
                end else if (command == ria_pkg::CMD_MULHSU) begin
                    seed.quo = ma; seed.dvs = operand_b; seed.neg_res = na;
                end else begin
                    seed.quo = operand_a; seed.dvs = operand_b;
                end
            end
            ria_pkg::CMD_DIV, ria_pkg::CMD_REM: begin
                seed.kind = (command == ria_pkg::CMD_DIV) ? ria_pkg::K_QUOT
                                                          : ria_pkg::K_REMD;
                seed.quo = ma; seed.dvs = mb;
                seed.neg_res = (command == ria_pkg::CMD_DIV) ? (na ^ nb) : na;
                if (bz)
                    seed.direct = (command == ria_pkg::CMD_DIV) ? 32'hffff_ffff : operand_a;
                else if (ovf)
                    seed.direct = (command == ria_pkg::CMD_DIV) ? operand_a : 32'd0;
                else
                    seed.use_direct = 1'b0;
            end
            ria_pkg::CMD_DIVU, ria_pkg::CMD_REMU: begin
                seed.kind = (command == ria_pkg::CMD_DIVU) ? ria_pkg::K_QUOT
                                                           : ria_pkg::K_REMD;
                seed.quo = operand_a; seed.dvs = operand_b;
                if (bz)
                    seed.direct = (command == ria_pkg::CMD_DIVU) ? 32'hffff_ffff : operand_a;
                else
                    seed.use_direct = 1'b0;
            end
            default: seed.direct = 32'd0;
        endcase
    end
endmodule
`default_nettype wire

/* hw/rtl/ria_cell.sv */
// One cell of the multiply/divide chain: one shift-add or restoring-divide step.
// Depends on ria_pkg.
`default_nettype none
module ria_cell (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire ria_pkg::cell_t d_in,
    output ria_pkg::cell_t      d_out
);
    ria_pkg::cell_t cell_reg, cell_next;
    logic [32:0] sum;
    logic [32:0] trial;
    logic [31:0] rs;

    // Multiply: add multiplicand (quo lsb selects), shift {rem,quo} right.
    // Divide: shift {rem,quo} left, try subtract divisor.
    always_comb begin
        cell_next = d_in;
        sum = {1'b0, d_in.rem} + (d_in.quo[0] ? {1'b0, d_in.dvs} : 33'd0);
        rs = {d_in.rem[30:0], d_in.quo[31]};
        trial = {d_in.rem[31], rs} - {1'b0, d_in.dvs};
        if (!d_in.use_direct) begin
            if (d_in.kind == ria_pkg::K_MULLO || d_in.kind == ria_pkg::K_MULHI) begin
                cell_next.rem = sum[32:1];
                cell_next.quo = {sum[0], d_in.quo[31:1]};
            end else begin
                cell_next.rem = trial[32] ? rs : trial[31:0];
                cell_next.quo = {d_in.quo[30:0], ~trial[32]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.vld <= 1'b0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    // Payload bits held without reset beside the valid flag.
    assign d_out = cell_reg;
endmodule
`default_nettype wire

/* hw/rtl/rv32im_integer_alu.sv */
// Integer ALU, RV32IM: 32-cell shift-add/restoring-divide chain plus output stage.
// Each command runs through every cell; one beat per cycle unless the output stalls.
// The chain length (one bit step per cell) sets latency; the chain stalls as a whole.
// Reset (aresetn low, synchronous) empties all cells; payload is not cleared.
// Depends on ria_pkg, ria_front, ria_cell.
`default_nettype none
module rv32im_integer_alu (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [4:0]  s_command,
    input  wire logic [31:0] s_operand_a,
    input  wire logic [31:0] s_operand_b,
    input  wire logic [4:0]  s_dest_reg,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_result_value
);
    ria_pkg::cell_t chain [ria_pkg::NumCells+1];
    logic        adv;
    logic        out_vld_reg;
    logic [31:0] out_val_reg;
    logic [31:0] fin, hi;
    ria_pkg::cell_t last;

    // Whole chain moves when the output slot is free or being emptied.
    assign adv     = !out_vld_reg || m_ready;
    assign s_ready = adv;

    ria_front u_front (
        .command(s_command), .operand_a(s_operand_a), .operand_b(s_operand_b),
        .dest_reg(s_dest_reg), .vld(s_valid), .seed(chain[0])
    );

    for (genvar i = 0; i < ria_pkg::NumCells; i++) begin : g_cell
        ria_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(adv),
            .d_in(chain[i]), .d_out(chain[i+1])
        );
    end

    assign last = chain[ria_pkg::NumCells];

    // Final select and sign fix.
    always_comb begin
        hi = last.neg_res ? ~last.rem + {31'd0, last.quo == 32'd0} : last.rem;
        case (last.kind)
            ria_pkg::K_MULLO: fin = last.quo;
            ria_pkg::K_MULHI: fin = hi;
            ria_pkg::K_QUOT:  fin = last.neg_res ? 32'd0 - last.quo : last.quo;
            ria_pkg::K_REMD:  fin = last.neg_res ? 32'd0 - last.rem : last.rem;
            default:          fin = last.direct;
        endcase
        if (last.use_direct) fin = last.direct;
        if (last.zero_rd) fin = 32'd0;
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= last.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) out_val_reg <= fin;
    end

    assign m_valid        = out_vld_reg;
    assign m_result_value = out_val_reg;
endmodule
`default_nettype wire

/* hw/rtl/ria_checker.sv */
// Port-level checker for the integer ALU, bound to the top level.
// Depends on rv32im_integer_alu_assert.svh.
`default_nettype none
`include "rv32im_integer_alu_assert.svh"
module ria_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_result_value
);
    // Stalled result beat holds.
    `RIA_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_result_value))
    // Input side never blocks while the output is free.
    `RIA_ASSERT_IMP(a_ready, aclk, aresetn, !m_valid, s_ready)
    // Output backpressure propagates to the input.
    `RIA_ASSERT_IMP(a_bp, aclk, aresetn, m_valid && !m_ready, !s_ready)
endmodule
bind rv32im_integer_alu ria_checker u_ria_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_result_value(m_result_value)
);
`default_nettype wire
